[sv/clamped_fixed_point_pi_step_top_defines.svh]
// Assertion helpers for the PI step block.
`ifndef CLAMPED_FIXED_POINT_PI_STEP_TOP_DEFINES_SVH
`define CLAMPED_FIXED_POINT_PI_STEP_TOP_DEFINES_SVH

// Clocked check, muted while reset is high.
`define CFPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs across reset.
`define CFPI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cfpi_pkg.sv]
package cfpi_pkg;

  localparam int IN_W   = 16;
  localparam int GAIN_W = 15;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam int KP_SHIFT = 8;
  localparam int KI_SHIFT = 8;
  // rounding window for the integral increment, wide enough for -(2^31-1)
  localparam logic signed [DATA_W+1:0] KI_PRECISION = 34'sd128;

  typedef logic signed [IN_W-1:0]   err_t;
  typedef logic        [GAIN_W-1:0] gain_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [DATA_W:0]   wide_t;
  typedef logic signed [DATA_W+1:0] prec_t;

  typedef enum logic [IDX_W-1:0] {
    REG_KP_GAIN = 3'd0,
    REG_KI_GAIN = 3'd1,
    REG_IN_MIN  = 3'd2,
    REG_IN_MAX  = 3'd3,
    REG_SUM_MIN = 3'd4,
    REG_SUM_MAX = 3'd5,
    REG_OUT_MIN = 3'd6,
    REG_OUT_MAX = 3'd7
  } reg_idx_t;

  localparam err_t  IN_MIN_RST  = 16'sh8000;
  localparam err_t  IN_MAX_RST  = 16'sh7FFF;
  localparam word_t WORD_MIN    = 32'sh8000_0000;
  localparam word_t WORD_MAX    = 32'sh7FFF_FFFF;

  // limits only apply when lo < hi
  function automatic err_t clamp_err(err_t v, err_t lo, err_t hi);
    err_t r;
    r = v;
    if (lo < hi) begin
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
    end
    return r;
  endfunction

  function automatic wide_t clamp_wide(wide_t v, word_t lo, word_t hi);
    wide_t r;
    wide_t lo_w;
    wide_t hi_w;
    lo_w = wide_t'(lo);
    hi_w = wide_t'(hi);
    r    = v;
    if (lo < hi) begin
      if (v < lo_w) r = lo_w;
      else if (v > hi_w) r = hi_w;
    end
    return r;
  endfunction

  function automatic word_t sat_word(wide_t v);
    word_t r;
    if (v[DATA_W] != v[DATA_W-1]) r = v[DATA_W] ? WORD_MIN : WORD_MAX;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

[sv/clamped_fixed_point_pi_step_top.sv]
// Clamped fixed-point PI controller step with integrator anti-windup.
// Error channel: err_valid / err_stall with err_in (signed 16 bit). One
//   transaction per control step.
// Result channel: out_valid / out_stall with drive_out (clamped controller
//   output) and integral_now (updated clamped integrator), one transaction
//   for each error transaction, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data. Index
//   0..7 = kp_gain, ki_gain, in_min, in_max, sum_min, sum_max, out_min,
//   out_max. cfg_ready is always high; write only while the block is idle.
// Path: the edge that takes an error transaction loads the input register, and the
//   result then moves through the product, integrator and output registers in order.
// Throughput: one transaction per cycle while out_stall is low. The integrator
//   feedback is combinational (increment add, clamp, saturate), so back-to-back
//   samples each see the integrator left by the previous one.
// Stall: when out_stall holds a full output register, the stages behind it
//   fill up and err_stall rises once all four are occupied; nothing is lost.
// Reset: synchronous, active high. Pipeline empties, integrator goes to zero,
//   gains go to zero and all limits open to their full range.
module clamped_fixed_point_pi_step_top (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      err_valid,
  output logic                                      err_stall,
  input  logic signed [cfpi_pkg::IN_W-1:0]          err_in,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [cfpi_pkg::DATA_W-1:0]        drive_out,
  output logic signed [cfpi_pkg::DATA_W-1:0]        integral_now,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic        [cfpi_pkg::IDX_W-1:0]         cfg_index,
  input  logic        [cfpi_pkg::DATA_W-1:0]        cfg_data
);

  // configuration registers
  cfpi_pkg::gain_t kp_gain;
  cfpi_pkg::gain_t ki_gain;
  cfpi_pkg::err_t  in_min;
  cfpi_pkg::err_t  in_max;
  cfpi_pkg::word_t sum_min;
  cfpi_pkg::word_t sum_max;
  cfpi_pkg::word_t out_min;
  cfpi_pkg::word_t out_max;

  // integrator state
  cfpi_pkg::word_t integral_acc;

  // stage valids
  logic err_vld;   // input register
  logic prod_vld;  // product register
  logic sum_vld;   // integrator register

  // stage payloads
  cfpi_pkg::err_t  err_q;
  cfpi_pkg::word_t kp_prod;
  cfpi_pkg::word_t ki_prod;
  cfpi_pkg::word_t pterm;
  cfpi_pkg::word_t pterm_q;
  cfpi_pkg::word_t sum_q;

  // combinational
  cfpi_pkg::err_t  err_clamped;
  cfpi_pkg::word_t inc_raw;
  cfpi_pkg::word_t inc;
  cfpi_pkg::prec_t ki_prod_ext;
  cfpi_pkg::word_t sum_next;
  cfpi_pkg::word_t drive_next;

  // a stage is free when empty or when it moves on this edge
  logic out_free;
  logic sum_free;
  logic prod_free;
  logic err_free;
  logic err_take;
  logic prod_take;
  logic sum_take;
  logic out_take;

  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid || !out_stall;
  assign sum_free  = !sum_vld   || out_free;
  assign prod_free = !prod_vld  || sum_free;
  assign err_free  = !err_vld   || prod_free;
  assign err_stall = !err_free;

  assign err_take  = err_valid && err_free;
  assign prod_take = err_vld   && prod_free;
  assign sum_take  = prod_vld  && sum_free;
  assign out_take  = sum_vld   && out_free;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= '0;
      ki_gain <= '0;
      in_min  <= cfpi_pkg::IN_MIN_RST;
      in_max  <= cfpi_pkg::IN_MAX_RST;
      sum_min <= cfpi_pkg::WORD_MIN;
      sum_max <= cfpi_pkg::WORD_MAX;
      out_min <= cfpi_pkg::WORD_MIN;
      out_max <= cfpi_pkg::WORD_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfpi_pkg::reg_idx_t'(cfg_index))
        cfpi_pkg::REG_KP_GAIN: kp_gain <= cfg_data[cfpi_pkg::GAIN_W-1:0];
        cfpi_pkg::REG_KI_GAIN: ki_gain <= cfg_data[cfpi_pkg::GAIN_W-1:0];
        cfpi_pkg::REG_IN_MIN:  in_min  <= cfg_data[cfpi_pkg::IN_W-1:0];
        cfpi_pkg::REG_IN_MAX:  in_max  <= cfg_data[cfpi_pkg::IN_W-1:0];
        cfpi_pkg::REG_SUM_MIN: sum_min <= cfg_data;
        cfpi_pkg::REG_SUM_MAX: sum_max <= cfg_data;
        cfpi_pkg::REG_OUT_MIN: out_min <= cfg_data;
        cfpi_pkg::REG_OUT_MAX: out_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage 1 -> 2: input clamp and both gain products ----
  // 16b signed x 15b unsigned fits 31 bits, so the 32b product never wraps
  assign err_clamped = cfpi_pkg::clamp_err(err_q, in_min, in_max);

  // ---- stage 2 -> 3: increment rounding and integrator update ----
  always_comb begin
    pterm       = kp_prod >>> cfpi_pkg::KP_SHIFT;
    inc_raw     = ki_prod >>> cfpi_pkg::KI_SHIFT;
    ki_prod_ext = cfpi_pkg::prec_t'(ki_prod);
    inc         = inc_raw;
    // small positive product rounds a zero step up, small negative one
    // drops a minus-one step to zero
    if (inc_raw == '0) begin
      if (ki_prod_ext > cfpi_pkg::KI_PRECISION) inc = cfpi_pkg::word_t'(1);
    end else if (&inc_raw) begin
      if (ki_prod_ext >= -cfpi_pkg::KI_PRECISION) inc = '0;
    end
    sum_next = cfpi_pkg::sat_word(cfpi_pkg::clamp_wide(
                 cfpi_pkg::wide_t'(integral_acc) + cfpi_pkg::wide_t'(inc),
                 sum_min, sum_max));
  end

  // ---- stage 3 -> out: output sum and clamp ----
  assign drive_next = cfpi_pkg::sat_word(cfpi_pkg::clamp_wide(
                        cfpi_pkg::wide_t'(pterm_q) + cfpi_pkg::wide_t'(sum_q),
                        out_min, out_max));

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      err_vld      <= 1'b0;
      prod_vld     <= 1'b0;
      sum_vld      <= 1'b0;
      out_valid    <= 1'b0;
      integral_acc <= '0;
    end else begin
      if (err_free)  err_vld   <= err_valid;
      if (prod_free) prod_vld  <= err_vld;
      if (sum_free)  sum_vld   <= prod_vld;
      if (out_free)  out_valid <= sum_vld;
      if (sum_take)  integral_acc <= sum_next;
    end
  end

  // ---- payload ----
  always_ff @(posedge clk) begin
    if (err_take) err_q <= err_in;
    if (prod_take) begin
      kp_prod <= cfpi_pkg::word_t'(err_clamped) *
                 cfpi_pkg::word_t'($signed({1'b0, kp_gain}));
      ki_prod <= cfpi_pkg::word_t'(err_clamped) *
                 cfpi_pkg::word_t'($signed({1'b0, ki_gain}));
    end
    if (sum_take) begin
      pterm_q <= pterm;
      sum_q   <= sum_next;
    end
    if (out_take) begin
      drive_out    <= drive_next;
      integral_now <= sum_q;
    end
  end

endmodule

[sv/cfpi_checker.sv]
`include "clamped_fixed_point_pi_step_top_defines.svh"

module cfpi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               err_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [cfpi_pkg::DATA_W-1:0] drive_out,
  input logic signed [cfpi_pkg::DATA_W-1:0] integral_now
);

  // a held result keeps its values
  `CFPI_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable({drive_out, integral_now}),
    "result changed while stalled")

  // back-pressure only reaches the input once the output is full and stalled
  `CFPI_ASSERT(a_stall_cause, err_stall |-> out_valid && out_stall,
    "input stalled without a stalled result")

  // the cycle after reset the pipeline is empty
  `CFPI_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !err_stall,
    "pipeline not empty after reset")

endmodule

bind clamped_fixed_point_pi_step_top cfpi_checker u_cfpi_checker (
  .clk          (clk),
  .rst          (rst),
  .err_stall    (err_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .drive_out    (drive_out),
  .integral_now (integral_now)
);
